### hdl/assert_macros.svh
// assertion helpers for the allocator checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication: consequent checked at the next clock edge after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/fla_pkg.sv
package fla_pkg;
  localparam int HeapBytes = 1024;
  localparam int HeaderBytes = 24;
  localparam int GranuleBytes = 8;
  localparam int Depth = HeapBytes / GranuleBytes;
  localparam int AW = $clog2(Depth);
  localparam int LW = AW + 1;
  localparam int SW = 10;
  localparam int HdrG = HeaderBytes / GranuleBytes;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_ARD, S_AWAIT, S_ASPLIT, S_ALINK, S_AUSE,
    S_FRD, S_FWAIT, S_FCHK, S_LRD, S_LWAIT, S_FLINK, S_DONE
  } state_t;

  // one entry of the block store: header fields packed together
  typedef struct packed {
    logic [SW-1:0] size;
    logic used;
    logic [LW-1:0] next;
  } entry_t;

  typedef struct packed {
    logic we;
    logic [AW-1:0] waddr;
    entry_t wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;
endpackage

### hdl/free_list_heap_allocator_core.sv
// alloc walks the free list, first fit or best fit as the fit strategy register selects;
//   free walks the block tiling to check the offset, then the free list for the predecessor
// out_valid rises in the done state; misaligned or too-small offsets reach it without a walk
// requests: one at a time, held busy while the list walks run
//   through the header store (one read per step); the receiver cannot stall
// reset: synchronous active-low rst_n; heap comes back as one free block
module free_list_heap_allocator_core (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic in_kind,
  input  logic [10:0] in_request_bytes,
  input  logic [9:0] in_free_offset,
  output logic out_valid,
  output logic [1:0] out_status,
  output logic [9:0] out_block_offset,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_fit_strategy
);
  // fit strategy register, writable whenever idle
  logic fit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) fit_r <= 1'b0;
    else if (cfg_valid && cfg_ready) fit_r <= cfg_fit_strategy;
  end
  assign cfg_ready = !busy;

  fla_pkg::mem_req_t mreq, mreq_core;
  fla_pkg::entry_t rdata;
  logic done;

  // header store; entry 0 is rewritten as a free block while reset is held
  always_comb begin
    mreq = mreq_core;
    if (!rst_n) begin
      mreq.we = 1'b1;
      mreq.waddr = '0;
      mreq.wdata.size = fla_pkg::SW'(fla_pkg::HeapBytes - fla_pkg::HeaderBytes);
      mreq.wdata.used = 1'b0;
      mreq.wdata.next = fla_pkg::LW'(fla_pkg::Depth);
    end
  end

  fla_store u_store (.clk(clk), .req(mreq), .rdata(rdata));

  fla_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .kind(in_kind),
    .req_bytes(in_request_bytes), .offset(in_free_offset), .fit_sel(fit_r),
    .rdata(rdata), .mreq(mreq_core), .busy(busy), .done(done),
    .status(out_status), .blk_off(out_block_offset)
  );

  assign out_valid = done;
endmodule

### hdl/fla_store.sv
module fla_store (
  input  logic clk,
  input  fla_pkg::mem_req_t req,
  output fla_pkg::entry_t rdata
);
  fla_pkg::entry_t mem [fla_pkg::Depth];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

### hdl/fla_ctrl.sv
module fla_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic kind,
  input  logic [10:0] req_bytes,
  input  logic [9:0] offset,
  input  logic fit_sel,
  input  fla_pkg::entry_t rdata,
  output fla_pkg::mem_req_t mreq,
  output logic busy,
  output logic done,
  output logic [1:0] status,
  output logic [9:0] blk_off
);
  localparam int AW = fla_pkg::AW;
  localparam int LW = fla_pkg::LW;
  localparam int SW = fla_pkg::SW;
  localparam logic [LW-1:0] NullL = LW'(fla_pkg::Depth);

  fla_pkg::state_t st_r, st_nxt;
  logic [LW-1:0] head_r, head_nxt;
  logic [LW-1:0] cur_r, cur_nxt, prev_r, prev_nxt;
  logic [LW-1:0] pick_r, pick_nxt, pprev_r, pprev_nxt, repl_r, repl_nxt;
  logic [SW-1:0] psize_r, psize_nxt;
  logic [LW-1:0] pnext_r, pnext_nxt;
  logic [11:0] need_r, need_nxt;
  logic [LW-1:0] g_r, g_nxt;
  logic [LW:0] steps_r, steps_nxt;
  logic [LW+1:0] p_r, p_nxt;
  logic [1:0] stat_r, stat_nxt;
  logic [9:0] off_r, off_nxt;
  logic best_r, best_nxt;
  logic [11:0] rem;
  logic [LW+1:0] nf;
  logic [LW+1:0] pstep;
  // predecessor next-link patch of a free, written in the cycle after the entry write
  logic link_pend_r, link_pend_nxt;
  logic [AW-1:0] link_addr_r;
  logic [LW-1:0] link_val_r;
  fla_pkg::entry_t link_ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= fla_pkg::S_IDLE;
      head_r <= '0;
    end else begin
      st_r <= st_nxt;
      head_r <= head_nxt;
    end
    cur_r <= cur_nxt; prev_r <= prev_nxt; pick_r <= pick_nxt; pprev_r <= pprev_nxt;
    repl_r <= repl_nxt; psize_r <= psize_nxt; pnext_r <= pnext_nxt; need_r <= need_nxt;
    g_r <= g_nxt; steps_r <= steps_nxt; p_r <= p_nxt; stat_r <= stat_nxt;
    off_r <= off_nxt; best_r <= best_nxt;
  end

  assign rem = 12'(psize_r) - need_r;
  assign nf = (LW+2)'(pick_r) + (LW+2)'((12'(fla_pkg::HeaderBytes) + need_r) >> 3);
  assign pstep = (LW+2)'((11'(fla_pkg::HeaderBytes) + 11'(rdata.size)) >> 3);

  always_comb begin
    st_nxt = st_r; head_nxt = head_r; cur_nxt = cur_r; prev_nxt = prev_r;
    pick_nxt = pick_r; pprev_nxt = pprev_r; repl_nxt = repl_r; psize_nxt = psize_r;
    pnext_nxt = pnext_r; need_nxt = need_r; g_nxt = g_r; steps_nxt = steps_r;
    p_nxt = p_r; stat_nxt = stat_r; off_nxt = off_r; best_nxt = best_r;
    unique case (st_r)
      fla_pkg::S_IDLE: begin
        if (start) begin
          best_nxt = fit_sel;
          need_nxt = (12'(req_bytes) + 12'd7) & ~12'd7;
          if (req_bytes == 11'd0) need_nxt = 12'd8;
          cur_nxt = head_r; prev_nxt = NullL; pick_nxt = NullL; pprev_nxt = NullL;
          steps_nxt = '0; p_nxt = '0; off_nxt = '0;
          g_nxt = LW'((offset - 10'(fla_pkg::HeaderBytes)) >> 3);
          if (!kind) begin
            st_nxt = fla_pkg::S_ARD;
          end else if (offset < 10'(fla_pkg::HeaderBytes) || offset[2:0] != 3'd0) begin
            stat_nxt = fla_pkg::ST_BADFREE; st_nxt = fla_pkg::S_DONE;
          end else begin
            st_nxt = fla_pkg::S_FRD;
          end
        end
      end
      fla_pkg::S_ARD: begin
        if (cur_r[AW] || steps_r >= (LW+1)'(fla_pkg::Depth)) begin
          if (pick_r[AW]) begin
            stat_nxt = fla_pkg::ST_NOFIT; st_nxt = fla_pkg::S_DONE;
          end else begin
            st_nxt = fla_pkg::S_ASPLIT;
          end
        end else begin
          st_nxt = fla_pkg::S_AWAIT;
        end
      end
      fla_pkg::S_AWAIT: begin
        st_nxt = fla_pkg::S_ARD;
        prev_nxt = cur_r; cur_nxt = rdata.next; steps_nxt = steps_r + 1'b1;
        if (12'(rdata.size) >= need_r) begin
          if (pick_r[AW] || rdata.size < psize_r) begin
            pick_nxt = cur_r; pprev_nxt = prev_r; psize_nxt = rdata.size;
            pnext_nxt = rdata.next;
          end
          if (!best_r) begin
            pick_nxt = cur_r; pprev_nxt = prev_r; psize_nxt = rdata.size;
            pnext_nxt = rdata.next; st_nxt = fla_pkg::S_ASPLIT;
          end
        end
      end
      fla_pkg::S_ASPLIT: begin
        st_nxt = fla_pkg::S_ALINK;
        repl_nxt = pnext_r;
        if (rem >= 12'(fla_pkg::HeaderBytes)) begin
          if (nf >= (LW+2)'(fla_pkg::Depth)) begin
            stat_nxt = fla_pkg::ST_NOFIT; st_nxt = fla_pkg::S_DONE;
          end else begin
            repl_nxt = LW'(nf); psize_nxt = SW'(need_r);
          end
        end
      end
      fla_pkg::S_ALINK: begin
        // relink the predecessor; head lives in a register
        if (pprev_r[AW]) head_nxt = repl_r;
        st_nxt = fla_pkg::S_AUSE;
      end
      fla_pkg::S_AUSE: begin
        stat_nxt = fla_pkg::ST_OK;
        off_nxt = 10'((12'(pick_r[AW-1:0]) << 3) + 12'(fla_pkg::HeaderBytes));
        st_nxt = fla_pkg::S_DONE;
      end
      fla_pkg::S_FRD: begin
        // walk block tiling to validate the offset
        if (p_r < (LW+2)'(g_r) && p_r < (LW+2)'(fla_pkg::Depth)
            && steps_r < (LW+1)'(fla_pkg::Depth)) begin
          st_nxt = fla_pkg::S_FWAIT;
        end else if (p_r != (LW+2)'(g_r) || g_r[AW]) begin
          stat_nxt = fla_pkg::ST_BADFREE; st_nxt = fla_pkg::S_DONE;
        end else begin
          st_nxt = fla_pkg::S_FCHK;
        end
      end
      fla_pkg::S_FWAIT: begin
        p_nxt = p_r + pstep; steps_nxt = steps_r + 1'b1; st_nxt = fla_pkg::S_FRD;
      end
      fla_pkg::S_FCHK: begin
        psize_nxt = rdata.size;
        if (!rdata.used) begin
          stat_nxt = fla_pkg::ST_BADFREE; st_nxt = fla_pkg::S_DONE;
        end else begin
          steps_nxt = '0; st_nxt = fla_pkg::S_LRD;
        end
      end
      fla_pkg::S_LRD: begin
        if (!cur_r[AW] && cur_r < g_r && steps_r < (LW+1)'(fla_pkg::Depth)) begin
          st_nxt = fla_pkg::S_LWAIT;
        end else begin
          st_nxt = fla_pkg::S_FLINK;
        end
      end
      fla_pkg::S_LWAIT: begin
        prev_nxt = cur_r; cur_nxt = rdata.next; steps_nxt = steps_r + 1'b1;
        st_nxt = fla_pkg::S_LRD;
      end
      fla_pkg::S_FLINK: begin
        if (prev_r[AW]) head_nxt = g_r;
        stat_nxt = fla_pkg::ST_OK; st_nxt = fla_pkg::S_DONE;
      end
      fla_pkg::S_DONE: st_nxt = fla_pkg::S_IDLE;
      default: st_nxt = fla_pkg::S_IDLE;
    endcase
  end

  // memory port: one read and at most one write per cycle
  always_comb begin
    mreq = '0;
    unique case (st_r)
      fla_pkg::S_ARD, fla_pkg::S_LRD: mreq.raddr = cur_r[AW-1:0];
      fla_pkg::S_FRD: mreq.raddr = p_r[AW-1:0];
      fla_pkg::S_ASPLIT: begin
        if (rem >= 12'(fla_pkg::HeaderBytes) && nf < (LW+2)'(fla_pkg::Depth)) begin
          mreq.we = 1'b1; mreq.waddr = AW'(nf);
          mreq.wdata.size = SW'(rem - 12'(fla_pkg::HeaderBytes));
          mreq.wdata.used = 1'b0; mreq.wdata.next = pnext_r;
        end
        mreq.raddr = pprev_r[AW-1:0];
      end
      fla_pkg::S_ALINK: begin
        // predecessor entry was read in the split cycle, patch its link
        mreq.raddr = pprev_r[AW-1:0];
        if (!pprev_r[AW]) begin
          mreq.we = 1'b1; mreq.waddr = pprev_r[AW-1:0];
          mreq.wdata = rdata; mreq.wdata.next = repl_r;
        end
      end
      fla_pkg::S_AUSE: begin
        mreq.we = 1'b1; mreq.waddr = pick_r[AW-1:0];
        mreq.wdata.size = psize_r; mreq.wdata.used = 1'b1; mreq.wdata.next = pnext_r;
      end
      fla_pkg::S_FLINK: begin
        mreq.we = 1'b1; mreq.waddr = g_r[AW-1:0];
        mreq.wdata.size = psize_r; mreq.wdata.used = 1'b0; mreq.wdata.next = cur_r;
      end
      fla_pkg::S_DONE: begin
        mreq.raddr = g_r[AW-1:0];
        if (link_pend_r) begin
          mreq.we = 1'b1; mreq.waddr = link_addr_r;
          mreq.wdata = link_ent_r; mreq.wdata.next = link_val_r;
        end
      end
      default: mreq.raddr = g_r[AW-1:0];
    endcase
  end

  assign busy = (st_r != fla_pkg::S_IDLE);
  assign done = (st_r == fla_pkg::S_DONE);
  assign status = stat_r;
  assign blk_off = off_r;

  // last node read by the list walk is the predecessor of the freed block
  assign link_pend_nxt = (st_r == fla_pkg::S_FLINK) && !prev_r[AW];
  always_ff @(posedge clk) begin
    if (!rst_n) link_pend_r <= 1'b0;
    else link_pend_r <= link_pend_nxt;
    link_addr_r <= prev_r[AW-1:0];
    link_val_r <= g_r;
    if (st_r == fla_pkg::S_LWAIT) link_ent_r <= rdata;
  end
endmodule

### hdl/fla_checker.sv
`include "assert_macros.svh"
module fla_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic [1:0] out_status,
  input logic [9:0] out_block_offset
);
  `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "request not taken")
  `ASSERT_CLK(a_res_busy, clk, rst_n, !out_valid || busy, "result while idle")
  `ASSERT_CLK(a_status, clk, rst_n, !out_valid || out_status <= fla_pkg::ST_BADFREE, "bad status")
  `ASSERT_CLK(a_off0, clk, rst_n, !out_valid || out_status == fla_pkg::ST_OK || out_block_offset == 10'd0,
    "offset on error")
  `ASSERT_NEXT(a_one, clk, rst_n, out_valid, !out_valid, "double result")
endmodule

bind free_list_heap_allocator_core fla_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_block_offset(out_block_offset)
);
